// ===== rtl/rfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared constants and types for the RFID frame parser with tag match.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // table geometry
  localparam int MAX_TAGS  = 16;
  localparam int TAG_BYTES = 12;

  localparam int SLOT_W  = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int POS_W   = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam int LIMIT_W = $clog2(MAX_TAGS + 1);
  localparam int FPOS_W  = $clog2(TAG_BYTES + 4);

  // frame positions after the tag bytes
  localparam int POS_CR  = TAG_BYTES + 1;
  localparam int POS_LF  = TAG_BYTES + 2;
  localparam int POS_ETX = TAG_BYTES + 3;

  // framing bytes
  localparam logic [7:0] BYTE_STX = 8'd2;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_ETX = 8'd3;

  // field widths fixed by the interface
  localparam int DATA_W   = 8;
  localparam int SLOT_IN_W = 4;
  localparam int BPOS_IN_W = 4;
  localparam int INDEX_W  = 4;
  localparam int RELOAD_W = 8;
  localparam int ACTIVE_W = 5;

  // input commands
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // result kinds
  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_MATCH = 1'b1;

  // configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_ACTIVE  = 1'b1;

  // queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ECHO  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MATCH = 2'd2
  } op_t;

  typedef logic [TAG_BYTES-1:0][7:0] tag_t;

  // one queued operation for the back end
  typedef struct packed {
    op_t                  op;
    logic [DATA_W-1:0]    data;
    logic [SLOT_IN_W-1:0] slot;
    logic [BPOS_IN_W-1:0] pos;
    tag_t                 frame;
  } qent_t;

  typedef struct packed {
    logic [RELOAD_W-1:0] timeout_reload;
    logic [ACTIVE_W-1:0] active_tags;
  } cfg_t;

endpackage

// ===== rtl/rfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_front
// Frame parser: tracks frame position, inactivity timer and collected tag
// bytes, and hands echo, table write and match operations to the queue.
// ----------------------------------------------------------------------------
module rfp_front
  import rfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           cmd,
  input  logic [DATA_W-1:0]    data_byte,
  input  logic [SLOT_IN_W-1:0] tag_slot,
  input  logic [BPOS_IN_W-1:0] byte_pos,
  input  cfg_t                 cfg,
  output logic                 q_push,
  output qent_t                q_ent
);

  logic [FPOS_W-1:0]   fpos, fpos_next;
  logic [RELOAD_W-1:0] tcount, tcount_next;
  tag_t                frame;
  logic                frame_we;

  // parse one transfer
  always_comb begin
    fpos_next   = fpos;
    tcount_next = tcount;
    frame_we    = 1'b0;
    q_push      = 1'b0;
    q_ent.op    = OP_ECHO;
    q_ent.data  = data_byte;
    q_ent.slot  = tag_slot;
    q_ent.pos   = byte_pos;
    q_ent.frame = frame;
    if (accept) begin
      unique case (cmd)
        CMD_WRITE: begin
          q_push   = 1'b1;
          q_ent.op = OP_WRITE;
        end
        CMD_TICK: begin
          if (tcount != '0) begin
            tcount_next = tcount - 1'b1;
            if (tcount == RELOAD_W'(1)) fpos_next = '0;
          end
        end
        CMD_BYTE: begin
          if (fpos == '0) begin
            q_push   = 1'b1;
            q_ent.op = OP_ECHO;
            if (data_byte == BYTE_STX) fpos_next = FPOS_W'(1);
          end else begin
            tcount_next = cfg.timeout_reload;
            priority if (fpos == FPOS_W'(POS_CR)) begin
              fpos_next = (data_byte == BYTE_CR) ? fpos + 1'b1 : '0;
            end else if (fpos == FPOS_W'(POS_LF)) begin
              fpos_next = (data_byte == BYTE_LF) ? fpos + 1'b1 : '0;
            end else if (fpos == FPOS_W'(POS_ETX)) begin
              fpos_next = '0;
              if (data_byte == BYTE_ETX) begin
                q_push   = 1'b1;
                q_ent.op = OP_MATCH;
              end
            end else if (fpos <= FPOS_W'(TAG_BYTES)) begin
              frame_we  = 1'b1;
              fpos_next = fpos + 1'b1;
            end else begin
              fpos_next = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fpos   <= '0;
      tcount <= '0;
    end else begin
      fpos   <= fpos_next;
      tcount <= tcount_next;
    end
  end

  // collected tag bytes
  always_ff @(posedge clk) begin
    if (frame_we) frame[POS_W'(fpos - 1'b1)] <= data_byte;
  end

endmodule

// ===== rtl/rfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_queue
// Short FIFO of operations between the parser front and the match back end.
// ----------------------------------------------------------------------------
module rfp_queue
  import rfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output qent_t head
);

  qent_t             entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_ent;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !pop)
    else $error("queue pop while empty");

endmodule

// ===== rtl/rfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_back
// Executes queued operations: tag table writes, idle echoes, and the
// slot-by-slot table scan for a completed frame; owns the output register.
// ----------------------------------------------------------------------------
module rfp_back
  import rfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  qent_t              head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic               m_tuser,
  output logic [15:0]        m_tdata
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FETCH = 3'b010,
    B_CMP   = 3'b100
  } bstate_t;

  bstate_t            state;
  tag_t               tag_mem [MAX_TAGS];
  tag_t               rd_data;
  tag_t               frame_q;
  logic [SLOT_W-1:0]  scan_idx;
  logic [LIMIT_W-1:0] limit_q, limit;
  logic               out_free, mem_we, last_slot, hit;
  logic [DATA_W-1:0]  echo_byte;
  logic [INDEX_W-1:0] tag_index;

  assign out_free  = !m_tvalid || m_tready;
  assign limit     = (int'(cfg.active_tags) > MAX_TAGS) ? LIMIT_W'(MAX_TAGS)
                                                        : LIMIT_W'(cfg.active_tags);
  assign last_slot = (LIMIT_W'(scan_idx) + 1'b1 == limit_q);
  assign hit       = (rd_data == frame_q);
  assign pop       = q_valid && (state == B_IDLE) && (head.op != OP_ECHO || out_free);
  assign mem_we    = pop && (head.op == OP_WRITE) && (int'(head.slot) < MAX_TAGS)
                     && (int'(head.pos) < TAG_BYTES);
  assign m_tdata   = {4'b0, tag_index, echo_byte};

  // tag table
  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[SLOT_W'(head.slot)][POS_W'(head.pos)] <= head.data;
    rd_data <= tag_mem[scan_idx];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
      scan_idx <= '0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (pop && head.op == OP_ECHO) begin
            m_tvalid <= 1'b1;
          end
          if (pop && head.op == OP_MATCH && limit != '0) begin
            scan_idx <= '0;
            state    <= B_FETCH;
          end
        end
        B_FETCH: state <= B_CMP;
        B_CMP: begin
          if (hit) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              state    <= B_IDLE;
            end
          end else if (last_slot) begin
            state <= B_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= B_FETCH;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop && head.op == OP_MATCH) begin
      frame_q <= head.frame;
      limit_q <= limit;
    end
    if (pop && head.op == OP_ECHO) begin
      m_tuser   <= KIND_ECHO;
      echo_byte <= head.data;
      tag_index <= '0;
    end else if (state == B_CMP && hit && out_free) begin
      m_tuser   <= KIND_MATCH;
      echo_byte <= '0;
      tag_index <= INDEX_W'(scan_idx);
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_CMP) |-> (LIMIT_W'(scan_idx) < limit_q))
    else $error("scan index beyond active slots");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("pending result overwritten");

endmodule

// ===== rtl/rfid_frame_parser_tag_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_frame_parser_tag_match
// RFID serial frame parser: STX, tag bytes, CR, LF, ETX, with tag table match.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): tuser carries the command (received byte, timer tick,
//   table byte write); tdata carries data_byte, tag_slot and byte_pos.
//   Output stream (m_*): tuser is the result kind (idle echo or tag match),
//   tdata holds echo_byte and tag_index; unused fields read as zero.
//   Config port: cfg_we with cfg_index 0 = timeout reload, 1 = active tags.
//   Parsing is done in the front at transfer time; operations pass through a
//   two-entry queue to the back end, which owns the tag table memory.
//   Flow: an echo passes through the queue, then the output register. A
//   complete frame is scanned slot by slot, each slot by a registered table
//   read, then a compare; a match result is registered from the compare that
//   hits. That scan sets the worst-case rate.
//   Ticks and table writes are absorbed at one per cycle while queue space
//   remains.
//   When the receiver stalls, the result is held in the output register and
//   the queue fills; s_tready drops once the queue is full.
//   Reset clears the parser to idle, the timer to zero and the config
//   registers to reload 100 and 16 active tags; the tag table is not cleared.
// ----------------------------------------------------------------------------
module rfid_frame_parser_tag_match
  import rfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // data_byte[7:0], tag_slot[11:8], byte_pos[15:12]
  input  logic [1:0]          s_tuser,   // cmd[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // echo_byte[7:0], tag_index[11:8], zero[15:12]
  output logic                m_tuser,   // kind[0]
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [RELOAD_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_in, q_head;

  assign s_tready = !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_reload <= RELOAD_W'(100);
      cfg.active_tags    <= ACTIVE_W'(MAX_TAGS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: cfg.timeout_reload <= cfg_data;
        CFG_ACTIVE:  cfg.active_tags    <= cfg_data[ACTIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && s_tready),
    .cmd       (s_tuser),
    .data_byte (s_tdata[7:0]),
    .tag_slot  (s_tdata[11:8]),
    .byte_pos  (s_tdata[15:12]),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_ent     (q_in)
  );

  rfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head     (q_head)
  );

  rfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== bench/rfid_frame_parser_tag_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_frame_parser_tag_match_tb
// Self-checking bench for the RFID frame parser with tag table match. It
// loads the whole tag table first, then sends a short directed run and a set
// of random phases. Each phase has its own timeout reload, active slot count
// and idle pattern. A behavioral model of the parser predicts every echo and
// match, and a monitor compares the output stream against it in order.
// ----------------------------------------------------------------------------
module rfid_frame_parser_tag_match_tb;
  import rfp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;     // longer than a full 16-slot scan
  localparam int SHOW_LIMIT    = 10;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic [3:0] slot;
    logic [3:0] pos;
    logic       drain_first;   // hold this item until all results are in
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] echo;
    logic [3:0] index;
  } tag_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  rfid_frame_parser_tag_match dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // stimulus and expectation stores
  rx_item_t    pending_items[$];
  tag_result_t awaited_results[$];
  rx_item_t    next_item;

  // traffic shaping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int queued_in_phase;
  bit in_taken = 1'b0;

  // bookkeeping
  int mismatches = 0;
  int items_taken = 0;
  int echoes_seen = 0;
  int matches_seen = 0;
  int frames_dropped_by_timeout = 0;

  // parser state as predicted
  int          frame_step;
  logic [7:0]  captured_tag [TAG_BYTES];
  logic [7:0]  idle_ticks_left;
  logic [7:0]  tag_store [MAX_TAGS][TAG_BYTES];
  logic [7:0]  tick_reload;
  logic [4:0]  slots_compared;

  // table shadow used only to steer generated frames toward hits
  logic [7:0]  gen_tags [MAX_TAGS][TAG_BYTES];

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // advance the predicted parser by one accepted transfer
  task automatic parse_and_match(input logic [1:0] cmd, input logic [7:0] data,
                                 input logic [3:0] slot, input logic [3:0] pos);
    tag_result_t want;
    int lim;
    int hit;
    bit same;
    case (cmd)
      CMD_WRITE: begin
        if (slot < MAX_TAGS && pos < TAG_BYTES) tag_store[slot][pos] = data;
      end
      CMD_TICK: begin
        if (idle_ticks_left != 0) begin
          idle_ticks_left--;
          if (idle_ticks_left == 0) begin
            if (frame_step != 0) frames_dropped_by_timeout++;
            frame_step = 0;
          end
        end
      end
      CMD_BYTE: begin
        if (frame_step == 0) begin
          want.kind  = KIND_ECHO;
          want.echo  = data;
          want.index = '0;
          awaited_results.push_back(want);
          if (data == BYTE_STX) frame_step = 1;
        end else begin
          idle_ticks_left = tick_reload;
          if (frame_step == POS_CR) begin
            frame_step = (data == BYTE_CR) ? frame_step + 1 : 0;
          end else if (frame_step == POS_LF) begin
            frame_step = (data == BYTE_LF) ? frame_step + 1 : 0;
          end else if (frame_step == POS_ETX) begin
            frame_step = 0;
            if (data == BYTE_ETX) begin
              lim = (slots_compared > MAX_TAGS) ? MAX_TAGS : slots_compared;
              hit = -1;
              for (int s = 0; s < lim && hit < 0; s++) begin
                same = 1'b1;
                for (int b = 0; b < TAG_BYTES; b++)
                  if (tag_store[s][b] != captured_tag[b]) same = 1'b0;
                if (same) hit = s;
              end
              if (hit >= 0) begin
                want.kind  = KIND_MATCH;
                want.echo  = '0;
                want.index = hit[3:0];
                awaited_results.push_back(want);
              end
            end
          end else begin
            captured_tag[frame_step - 1] = data;
            frame_step++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // input transfers, output transfers and register writes
  always @(posedge clk) begin
    tag_result_t got;
    tag_result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind  = m_tuser;
        got.echo  = m_tdata[7:0];
        got.index = m_tdata[11:8];
        if (got.kind == KIND_MATCH) matches_seen++;
        else echoes_seen++;
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind=%0d echo=%02h index=%0d",
                                  got.kind, got.echo, got.index));
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind || got.echo !== want.echo || got.index !== want.index)
            note_mismatch($sformatf("want kind=%0d echo=%02h index=%0d, got kind=%0d echo=%02h index=%0d",
                                    want.kind, want.echo, want.index,
                                    got.kind, got.echo, got.index));
        end
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        items_taken++;
        parse_and_match(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[15:12]);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) tick_reload = cfg_data;
        else slots_compared = cfg_data[4:0];
      end
    end else begin
      frame_step      = 0;
      idle_ticks_left = '0;
      tick_reload     = 8'd100;
      slots_compared  = 5'd16;
    end
  end

  // sender: present the next queued item, or idle
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_items.size() > 0 &&
          (!pending_items[0].drain_first || awaited_results.size() == 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {next_item.pos, next_item.slot, next_item.data};
        s_tuser  <= next_item.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [3:0] slot, input logic [3:0] pos);
    rx_item_t it;
    it.cmd         = cmd;
    it.data        = data;
    it.slot        = slot;
    it.pos         = pos;
    it.drain_first = ($urandom_range(199) == 0);
    pending_items.push_back(it);
    queued_in_phase++;
  endtask

  // byte or tick with the unused fields randomized
  task automatic queue_plain(input logic [1:0] cmd, input logic [7:0] data);
    queue_item(cmd, data, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic queue_table_write(input int slot, input int pos, input logic [7:0] data);
    if (pos < TAG_BYTES) gen_tags[slot][pos] = data;
    queue_item(CMD_WRITE, data, slot[3:0], pos[3:0]);
  endtask

  // one random sequence: mostly frames, some table updates, noise, stale frames
  task automatic add_sequence(input int reload);
    int r;
    int src;
    int nticks;
    int tick_at;
    int bad_at;
    int k;
    int cut;
    logic [7:0] body [TAG_BYTES];
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 55 || (r >= 85 && (reload == 0 || reload > TAG_BYTES))) begin
      // complete frame, with a bad trailer byte in the broken share
      src = $urandom_range(MAX_TAGS - 1);
      for (k = 0; k < TAG_BYTES; k++)
        body[k] = ($urandom_range(9) < 7) ? gen_tags[src][k] : 8'($urandom_range(255));
      bad_at = (r >= 55) ? $urandom_range(2) : -1;
      nticks = 0;
      if ($urandom_range(4) == 0)
        nticks = (reload == 0) ? $urandom_range(1, 3) :
                 $urandom_range(0, (reload - 1 < 3) ? reload - 1 : 3);
      tick_at = $urandom_range(1, TAG_BYTES + 2);
      queue_plain(CMD_BYTE, BYTE_STX);
      for (k = 0; k < TAG_BYTES + 3; k++) begin
        if (k == tick_at)
          repeat (nticks) queue_plain(CMD_TICK, 8'($urandom_range(255)));
        if (k < TAG_BYTES) b = body[k];
        else if (k == TAG_BYTES) b = BYTE_CR;
        else if (k == TAG_BYTES + 1) b = BYTE_LF;
        else b = BYTE_ETX;
        if (bad_at >= 0 && k - TAG_BYTES == bad_at) b = b ^ 8'($urandom_range(1, 255));
        queue_plain(CMD_BYTE, b);
      end
    end else if (r < 70) begin
      // table update: a few bytes, or a whole new tag for one slot
      src = $urandom_range(MAX_TAGS - 1);
      if ($urandom_range(4) == 0) begin
        for (k = 0; k < TAG_BYTES; k++) queue_table_write(src, k, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_table_write($urandom_range(MAX_TAGS - 1),
                            ($urandom_range(9) < 8) ? $urandom_range(TAG_BYTES - 1) :
                                                      $urandom_range(TAG_BYTES, 15),
                            8'($urandom_range(255)));
      end
    end else if (r < 85) begin
      // noise while idle: stray bytes, ticks and the unused command
      repeat ($urandom_range(1, 4)) begin
        k = $urandom_range(9);
        if (k < 6) queue_plain(CMD_BYTE, 8'($urandom_range(255)));
        else if (k < 9) queue_plain(CMD_TICK, 8'($urandom_range(255)));
        else queue_plain(CMD_UNUSED, 8'($urandom_range(255)));
      end
    end else begin
      // partial frame left to go stale, sometimes one tick short of abandon
      cut = $urandom_range(1, TAG_BYTES + 2);
      queue_plain(CMD_BYTE, BYTE_STX);
      for (k = 0; k < cut; k++) begin
        if (k < TAG_BYTES) b = 8'($urandom_range(255));
        else if (k == TAG_BYTES) b = BYTE_CR;
        else b = BYTE_LF;
        queue_plain(CMD_BYTE, b);
      end
      nticks = ($urandom_range(3) == 0) ? reload - 1 : reload + $urandom_range(2);
      repeat (nticks) queue_plain(CMD_TICK, 8'($urandom_range(255)));
    end
  endtask

  // everything sent, every result back, and any silent scan finished
  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || s_tvalid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int reload, input int active, input int send_pct,
                           input int recv_pct, input int hold, input int n_items);
    wait_quiet();
    write_cfg(CFG_TIMEOUT, reload[7:0]);
    write_cfg(CFG_ACTIVE, active[7:0]);
    @(posedge clk);
    #1;
    send_idle_pct   = send_pct;
    recv_stall_pct  = recv_pct;
    hold_left       = hold;
    queued_in_phase = 0;
    while (queued_in_phase < n_items) add_sequence(reload);
  endtask

  // run limit
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill every slot: all-zero and all-ones tags, framing values inside a tag,
    // and a duplicate so the lowest slot must win
    for (int s = 0; s < MAX_TAGS; s++)
      for (int b = 0; b < TAG_BYTES; b++) begin
        if (s == 0) gen_tags[s][b] = 8'h00;
        else if (s == MAX_TAGS - 1) gen_tags[s][b] = 8'hFF;
        else if (s == 11) gen_tags[s][b] = gen_tags[3][b];
        else if (s == 6 && b < 4) gen_tags[s][b] = (b == 0) ? BYTE_STX : (b == 1) ? BYTE_CR :
                                                   (b == 2) ? BYTE_LF : BYTE_ETX;
        else gen_tags[s][b] = 8'($urandom_range(255));
        queue_table_write(s, b, gen_tags[s][b]);
      end

    // directed: idle echo extremes, ignored command, tick at zero,
    // out-of-range table writes, then a frame that hits the duplicated tag
    queue_item(CMD_BYTE, 8'h00, 4'h0, 4'h0);
    queue_item(CMD_BYTE, 8'hFF, 4'hF, 4'hF);
    queue_item(CMD_UNUSED, 8'hFF, 4'hF, 4'hF);
    queue_item(CMD_TICK, 8'h00, 4'h0, 4'h0);
    queue_item(CMD_WRITE, 8'hAA, 4'hF, 4'(TAG_BYTES));
    queue_item(CMD_WRITE, 8'h55, 4'h0, 4'hF);
    queue_item(CMD_BYTE, BYTE_STX, 4'h0, 4'h0);
    for (int b = 0; b < TAG_BYTES; b++) queue_item(CMD_BYTE, gen_tags[11][b], 4'h0, 4'h0);
    queue_item(CMD_BYTE, BYTE_CR, 4'h0, 4'h0);
    queue_item(CMD_BYTE, BYTE_LF, 4'h0, 4'h0);
    queue_item(CMD_BYTE, BYTE_ETX, 4'h0, 4'h0);

    // random phases: reload, active slots, sender idle %, receiver stall %,
    // hold-off cycles, items
    run_phase(100, 16,  0,  0, 400, 220);
    run_phase(  0, 16, 72,  0,   0, 220);
    run_phase(  1,  0,  0, 72,   0, 220);
    run_phase(255, 31, 23, 23,   0, 220);
    run_phase(  3,  1,  0,  0,   0, 220);
    run_phase( 12, 17, 72,  0,   0, 220);
    run_phase(  5,  8,  0, 72,   0, 220);
    run_phase(  2, 16, 23, 23,   0, 220);
    wait_quiet();

    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    $display("covered %0d input transfers: %0d echoes, %0d tag matches checked",
             items_taken, echoes_seen, matches_seen);
    $display("%0d partial frames abandoned by the inactivity timer, %0d mismatches",
             frames_dropped_by_timeout, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
